/* sv/rrns_pkg.sv */
package rrns_pkg;

	localparam int SLOT_FIELDS     = 5;
	localparam int DEF_MAX_VOICES  = 5;
	localparam int DEF_DELAY_TICKS = 5;

	// Schmitt thresholds at 1/1024 V per code: 2 V and 0.1 V
	localparam logic signed [15:0] HIGH_CODE = 16'sd2048;
	localparam logic signed [15:0] LOW_CODE  = 16'sd102;

	localparam logic [2:0] RESET_VOICE_COUNT = 3'd2;

	typedef logic signed [15:0] sample_t;

	typedef enum logic [1:0] {
		MODE_RISE = 2'd0,
		MODE_FALL = 2'd1,
		MODE_NEXT = 2'd2
	} capture_mode_t;

	typedef struct packed {
		logic [2:0] voice_count;
		logic [1:0] capture_mode;
	} cfg_t;

	typedef struct packed {
		sample_t [SLOT_FIELDS-1:0] pitch;
		logic [SLOT_FIELDS-1:0]    gate_mask;
		logic [2:0]                current_slot;
	} result_t;

endpackage

/* sv/rrns_delay.sv */
module rrns_delay #(
	parameter int DELAY_TICKS = rrns_pkg::DEF_DELAY_TICKS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  rrns_pkg::sample_t pitch_in,
	input  rrns_pkg::sample_t gate_in,
	output rrns_pkg::sample_t old_pitch,
	output rrns_pkg::sample_t old_gate
);

	rrns_pkg::sample_t pitch_hist_q [DELAY_TICKS];
	rrns_pkg::sample_t gate_hist_q  [DELAY_TICKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DELAY_TICKS; i++) begin
				pitch_hist_q[i] <= '0;
				gate_hist_q[i]  <= '0;
			end
		end else if (shift) begin
			pitch_hist_q[0] <= pitch_in;
			gate_hist_q[0]  <= gate_in;
			for (int i = 1; i < DELAY_TICKS; i++) begin
				pitch_hist_q[i] <= pitch_hist_q[i-1];
				gate_hist_q[i]  <= gate_hist_q[i-1];
			end
		end
	end

	// oldest sample, read before this word shifts in
	assign old_pitch = pitch_hist_q[DELAY_TICKS-1];
	assign old_gate  = gate_hist_q[DELAY_TICKS-1];

endmodule

/* sv/rrns_alloc.sv */
module rrns_alloc #(
	parameter int MAX_VOICES  = rrns_pkg::DEF_MAX_VOICES,
	parameter int DELAY_TICKS = rrns_pkg::DEF_DELAY_TICKS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  rrns_pkg::sample_t pitch_in,
	input  rrns_pkg::sample_t gate_in,
	input  rrns_pkg::cfg_t    cfg,
	output rrns_pkg::result_t result
);

	localparam int PW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int XW = ((PW > 3) ? PW : 3) + 1;

	rrns_pkg::sample_t old_pitch;
	rrns_pkg::sample_t old_gate;

	rrns_delay #(
		.DELAY_TICKS(DELAY_TICKS)
	) u_delay (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (accept),
		.pitch_in (pitch_in),
		.gate_in  (gate_in),
		.old_pitch(old_pitch),
		.old_gate (old_gate)
	);

	rrns_pkg::sample_t store_q [MAX_VOICES];
	logic [PW-1:0]     ptr_q;
	logic [2:0]        prev_q;
	logic              high_q;

	rrns_pkg::sample_t       st [MAX_VOICES];
	logic [2:0]              count_c;
	rrns_pkg::capture_mode_t mode_c;
	logic                    shrink;
	logic [PW-1:0]           ptr1;
	logic [PW-1:0]           ptr2;
	rrns_pkg::sample_t       trig;
	logic                    hi_sense;
	logic                    above;
	logic                    below;
	logic                    go_high;
	logic                    go_low;
	logic                    rise;
	logic                    high_n;
	logic                    wrap;
	logic                    gate_on;
	rrns_pkg::sample_t       slot_w [rrns_pkg::SLOT_FIELDS];

	always_comb begin
		if (cfg.voice_count == 3'd0) begin
			count_c = 3'd1;
		end else if (int'(cfg.voice_count) > MAX_VOICES) begin
			count_c = 3'(MAX_VOICES);
		end else begin
			count_c = cfg.voice_count;
		end
	end

	always_comb begin
		unique case (cfg.capture_mode)
			rrns_pkg::MODE_FALL: mode_c = rrns_pkg::MODE_FALL;
			rrns_pkg::MODE_NEXT: mode_c = rrns_pkg::MODE_NEXT;
			default:             mode_c = rrns_pkg::MODE_RISE;
		endcase
	end

	assign shrink = count_c < prev_q;

	always_comb begin
		st   = store_q;
		ptr1 = ptr_q;

		// shrinking: pointer falls off the end, so its pitch moves to slot 0
		if (shrink && (XW'(ptr_q) >= XW'(count_c))) begin
			st[0] = store_q[ptr_q];
			ptr1  = '0;
		end
		for (int i = 0; i < MAX_VOICES; i++) begin
			if (shrink && (i >= int'(count_c)) && (i < int'(prev_q))) begin
				st[i] = '0;
			end
		end

		trig     = (mode_c == rrns_pkg::MODE_RISE) ? old_gate : gate_in;
		hi_sense = mode_c != rrns_pkg::MODE_FALL;
		above    = trig >= rrns_pkg::HIGH_CODE;
		below    = trig <= rrns_pkg::LOW_CODE;
		go_high  = hi_sense ? above : below;
		go_low   = hi_sense ? below : above;
		rise     = !high_q && go_high;
		high_n   = high_q ? !go_low : go_high;

		wrap = (XW'(ptr1) + XW'(1)) == XW'(count_c);
		ptr2 = rise ? (wrap ? '0 : ptr1 + PW'(1)) : ptr1;

		unique case (mode_c)
			rrns_pkg::MODE_NEXT: begin
				st[ptr2] = old_pitch;
			end
			rrns_pkg::MODE_FALL: begin
				if (!high_n) begin
					st[ptr2] = pitch_in;
				end
			end
			default: begin
				if (rise) begin
					st[ptr2] = pitch_in;
				end
			end
		endcase

		gate_on = (mode_c == rrns_pkg::MODE_FALL) ? !high_n : high_n;
	end

	for (genvar g = 0; g < rrns_pkg::SLOT_FIELDS; g++) begin : g_slot
		if (g < MAX_VOICES) begin : g_used
			assign slot_w[g] = (g < int'(count_c)) ? st[g] : '0;
		end else begin : g_none
			assign slot_w[g] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < rrns_pkg::SLOT_FIELDS; i++) begin
			result.pitch[i]     = slot_w[i];
			result.gate_mask[i] = gate_on && (XW'(ptr2) == XW'(i));
		end
		result.current_slot = 3'(ptr2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_VOICES; i++) begin
				store_q[i] <= '0;
			end
			ptr_q  <= '0;
			prev_q <= '0;
			high_q <= 1'b1;
		end else if (accept) begin
			store_q <= st;
			ptr_q   <= ptr2;
			prev_q  <= count_c;
			high_q  <= high_n;
		end
	end

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(ptr_q) < MAX_VOICES)
		else $error("slot pointer beyond voice slots");

	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(result.gate_mask))
		else $error("more than one gate set");

	a_ptr_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (int'(ptr_q) < int'($past(count_c))))
		else $error("slot pointer not below voice count");

endmodule

/* sv/round_robin_note_splitter.sv */
// Round-robin note splitter: deals a mono pitch/gate stream across voice slots.
// Input channel: pitch_in and gate_in, one word per audio tick, taken when
// in_valid is high and in_stall is low.
// Output channel: all slot pitches, gate_mask and current_slot, one word per
// input word, offered on out_valid and held while out_stall is high.
// Config channel: cfg_index 0 voice count, 1 capture mode, written on cfg_valid
// with cfg_ready; cfg_ready is always high. Write only while the block is idle.
// Output: the result is registered into the output register on acceptance.
// Throughput: one word per cycle while in_stall is low; the slot logic sits between
// the input handshake and the single output register.
// Stall: in_stall rises only while a result waits and out_stall is high, so a
// word is taken in the same cycle that the waiting result leaves.
// Reset: slots and delay lines clear to zero, two voices, latch on gate rise,
// trigger high, pointer at slot 0, output empty.
module round_robin_note_splitter #(
	parameter int MAX_VOICES  = rrns_pkg::DEF_MAX_VOICES,
	parameter int DELAY_TICKS = rrns_pkg::DEF_DELAY_TICKS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [15:0]      pitch_in,
	input  logic signed [15:0]      gate_in,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [15:0]      slot0_pitch,
	output logic signed [15:0]      slot1_pitch,
	output logic signed [15:0]      slot2_pitch,
	output logic signed [15:0]      slot3_pitch,
	output logic signed [15:0]      slot4_pitch,
	output logic [4:0]              gate_mask,
	output logic [2:0]              current_slot,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [2:0]              cfg_data
);

	localparam logic CFG_VOICE_COUNT  = 1'b0;
	localparam logic CFG_CAPTURE_MODE = 1'b1;

	rrns_pkg::cfg_t    cfg_q;
	rrns_pkg::result_t res_c;
	rrns_pkg::result_t result_q;
	logic              out_valid_q;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voice_count  <= rrns_pkg::RESET_VOICE_COUNT;
			cfg_q.capture_mode <= rrns_pkg::MODE_RISE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VOICE_COUNT:  cfg_q.voice_count  <= cfg_data;
				CFG_CAPTURE_MODE: cfg_q.capture_mode <= cfg_data[1:0];
			endcase
		end
	end

	rrns_alloc #(
		.MAX_VOICES (MAX_VOICES),
		.DELAY_TICKS(DELAY_TICKS)
	) u_alloc (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.pitch_in(pitch_in),
		.gate_in (gate_in),
		.cfg     (cfg_q),
		.result  (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= res_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign slot0_pitch  = result_q.pitch[0];
	assign slot1_pitch  = result_q.pitch[1];
	assign slot2_pitch  = result_q.pitch[2];
	assign slot3_pitch  = result_q.pitch[3];
	assign slot4_pitch  = result_q.pitch[4];
	assign gate_mask    = result_q.gate_mask;
	assign current_slot = result_q.current_slot;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no word waiting");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word did not reach output register");

	a_drain_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !in_valid) |=> !out_valid_q)
		else $error("output word repeated");

endmodule
